// ----- rtl/core/rle8bd_pkg.sv -----
// Shared types and constants for the RLE8 bitmap decoder.
package rle8bd_pkg;

  // Parser phase of the byte stream.
  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_VALUE   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_DRIGHT  = 3'd3,
    PH_DDOWN   = 3'd4,
    PH_LITERAL = 3'd5,
    PH_PAD     = 3'd6
  } phase_t;

  // Escape codes that follow a zero count byte.
  localparam logic [7:0] ESC_EOL   = 8'h00;
  localparam logic [7:0] ESC_EOB   = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;

  // Configuration register indexes.
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // One input item.
  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_image;
  } in_item_t;

  // One result item: a fill command.
  typedef struct packed {
    logic [23:0] pixel_index;
    logic [7:0]  run_length;
    logic [7:0]  pixel_value;
    logic        image_done;
    logic        clipped;
  } out_item_t;

endpackage

// ----- rtl/core/rle8_bitmap_decoder_core.sv -----
// RLE8 bitmap decoder: turns an encoded byte stream into pixel fill commands.
//
// The decoder takes one encoded byte per clock cycle while in_stall is low
// and produces at most one fill command per byte, which is registered. All
// parsing, clipping and position updates for a byte are combinational,
// between the parser state registers and the output stage. A two-entry output
// stage (result register plus skid register) lets a byte be taken while a
// result waits; in_stall rises only when both entries hold results. Runs are
// clipped at the line end (flagged by clipped), and once the image is full or
// the end-of-bitmap escape arrives, bytes are dropped until start_image.
// Width and height may be written only while the decoder is idle.
module rle8_bitmap_decoder_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rle8bd_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rle8bd_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic [12:0]           cfg_wdata
);
  import rle8bd_pkg::*;

  // Configuration registers.
  logic [12:0] width_r;
  logic [12:0] height_r;

  // Parser and position state.
  phase_t      phase_r,    phase_nxt;
  logic [7:0]  pend_r,     pend_nxt;
  logic [12:0] col_r,      col_nxt;
  logic [12:0] row_r,      row_nxt;
  logic [23:0] base_r,     base_nxt;
  logic [7:0]  dright_r,   dright_nxt;
  logic        pad_r,      pad_nxt;
  logic        fin_r,      fin_nxt;

  // Output stage.
  logic        out_vld_r,  out_vld_nxt;
  out_item_t   out_r,      out_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  out_item_t   skid_r,     skid_nxt;

  // Per-item working values.
  logic        in_acc;
  logic        out_take;
  logic [7:0]  b;
  logic [12:0] eff_w;
  logic [12:0] eff_h;
  phase_t      cur_phase;
  logic [7:0]  cur_pend;
  logic [12:0] cur_col;
  logic [12:0] cur_row;
  logic [23:0] cur_base;
  logic [7:0]  cur_dright;
  logic        cur_pad;
  logic        cur_fin;
  logic [7:0]  run_len;
  logic [12:0] room;
  logic [12:0] run_n;
  logic [12:0] run_col;
  logic        run_full;
  logic [13:0] dcol_sum;
  logic [12:0] dcol;
  logic [12:0] drow;
  logic [20:0] dprod;
  logic [12:0] erow;
  logic        eol_full;
  logic        ddown_full;
  logic        res_vld;
  out_item_t   res;

  // Image is full when past the last line, or at the end of the last line.
  function automatic logic is_full(input logic [12:0] r, input logic [12:0] c,
                                   input logic [12:0] w, input logic [12:0] h);
    logic [13:0] r1;
    r1 = {1'b0, r} + 14'd1;
    return (r >= h) || ((r1 >= {1'b0, h}) && (c >= w));
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_vld_r && !out_stall;
  assign b        = in_data.code_byte;

  // Registers are used clamped to 1..MAX.
  always_comb begin
    if (width_r == 13'd0) begin
      eff_w = 13'd1;
    end else if (width_r > 13'(MAX_WIDTH)) begin
      eff_w = 13'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == 13'd0) begin
      eff_h = 13'd1;
    end else if (height_r > 13'(MAX_HEIGHT)) begin
      eff_h = 13'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  // A start flag clears position and parser state before the byte is used.
  always_comb begin
    if (in_data.start_image) begin
      cur_phase  = PH_COUNT;
      cur_pend   = 8'd0;
      cur_col    = 13'd0;
      cur_row    = 13'd0;
      cur_base   = 24'd0;
      cur_dright = 8'd0;
      cur_pad    = 1'b0;
      cur_fin    = 1'b0;
    end else begin
      cur_phase  = phase_r;
      cur_pend   = pend_r;
      cur_col    = col_r;
      cur_row    = row_r;
      cur_base   = base_r;
      cur_dright = dright_r;
      cur_pad    = pad_r;
      cur_fin    = fin_r;
    end
  end

  // Run emission: cut the run to the room left on the line.
  always_comb begin
    run_len  = (cur_phase == PH_LITERAL) ? 8'd1 : cur_pend;
    room     = (cur_col < eff_w) ? (eff_w - cur_col) : 13'd0;
    run_n    = ({5'd0, run_len} < room) ? {5'd0, run_len} : room;
    run_col  = cur_col + run_n;
    run_full = is_full(cur_row, run_col, eff_w, eff_h);
  end

  // Delta and end-of-line position updates.
  always_comb begin
    dcol_sum   = {1'b0, cur_col} + {6'd0, cur_dright};
    dcol       = (dcol_sum < {1'b0, eff_w}) ? dcol_sum[12:0] : eff_w;
    drow       = cur_row + {5'd0, b};
    dprod      = {13'd0, b} * {8'd0, eff_w};
    erow       = cur_row + 13'd1;
    eol_full   = is_full(erow, 13'd0, eff_w, eff_h);
    ddown_full = is_full(drow, dcol, eff_w, eff_h);
  end

  // Parser: next state for the current byte.
  always_comb begin
    phase_nxt  = cur_phase;
    pend_nxt   = cur_pend;
    col_nxt    = cur_col;
    row_nxt    = cur_row;
    base_nxt   = cur_base;
    dright_nxt = cur_dright;
    pad_nxt    = cur_pad;
    fin_nxt    = cur_fin;
    if (!cur_fin) begin
      unique case (cur_phase)
        PH_VALUE: begin
          phase_nxt = PH_COUNT;
          col_nxt   = run_col;
          fin_nxt   = run_full;
        end
        PH_ESCAPE: begin
          priority if (b == ESC_EOL) begin
            phase_nxt = PH_COUNT;
            col_nxt   = 13'd0;
            row_nxt   = erow;
            base_nxt  = cur_base + {11'd0, eff_w};
            if (eol_full) begin
              fin_nxt = 1'b1;
            end
          end else if (b == ESC_EOB) begin
            phase_nxt = PH_COUNT;
            fin_nxt   = 1'b1;
          end else if (b == ESC_DELTA) begin
            phase_nxt = PH_DRIGHT;
          end else begin
            pend_nxt  = b;
            pad_nxt   = b[0];
            phase_nxt = PH_LITERAL;
          end
        end
        PH_DRIGHT: begin
          dright_nxt = b;
          phase_nxt  = PH_DDOWN;
        end
        PH_DDOWN: begin
          col_nxt   = dcol;
          row_nxt   = drow;
          base_nxt  = cur_base + {3'd0, dprod};
          phase_nxt = PH_COUNT;
          if (ddown_full) begin
            fin_nxt = 1'b1;
          end
        end
        PH_LITERAL: begin
          pend_nxt = cur_pend - 8'd1;
          if (cur_pend == 8'd1) begin
            phase_nxt = cur_pad ? PH_PAD : PH_COUNT;
          end
          col_nxt = run_col;
          fin_nxt = run_full;
        end
        PH_PAD: begin
          pad_nxt   = 1'b0;
          phase_nxt = PH_COUNT;
        end
        default: begin
          if (b == 8'd0) begin
            phase_nxt = PH_ESCAPE;
          end else begin
            pend_nxt  = b;
            phase_nxt = PH_VALUE;
          end
        end
      endcase
    end
  end

  // Parser: result for the current byte, a fill command or a bare done marker.
  always_comb begin
    res_vld        = 1'b0;
    res            = '0;
    res.image_done = 1'b1;
    if (!cur_fin) begin
      unique case (cur_phase)
        PH_VALUE, PH_LITERAL: begin
          res_vld         = 1'b1;
          res.pixel_index = cur_base + {11'd0, cur_col};
          res.run_length  = run_n[7:0];
          res.pixel_value = b;
          res.image_done  = run_full;
          res.clipped     = ({5'd0, run_len} > room);
        end
        PH_ESCAPE: begin
          res_vld = (b == ESC_EOL) ? eol_full : (b == ESC_EOB);
        end
        PH_DDOWN: begin
          res_vld = ddown_full;
        end
        default: begin
          res_vld = 1'b0;
        end
      endcase
    end
  end

  // Output stage: result register with a skid register behind it.
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || out_take) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else if (in_acc && res_vld) begin
        out_vld_nxt = 1'b1;
        out_nxt     = res;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (in_acc && res_vld) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      phase_r    <= PH_COUNT;
      pend_r     <= 8'd0;
      col_r      <= 13'd0;
      row_r      <= 13'd0;
      base_r     <= 24'd0;
      dright_r   <= 8'd0;
      pad_r      <= 1'b0;
      fin_r      <= 1'b0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
          CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_r  <= phase_nxt;
        pend_r   <= pend_nxt;
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        base_r   <= base_nxt;
        dright_r <= dright_nxt;
        pad_r    <= pad_nxt;
        fin_r    <= fin_nxt;
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall  = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/rle8bd_checker.sv -----
// Port-level checks for the RLE8 bitmap decoder, bound to the top level.
module rle8bd_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input rle8bd_pkg::out_item_t out_data
);
  import rle8bd_pkg::*;

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  // The input only stalls when a result is already waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // A zero-length result that is not clipped must be a bare done marker.
  a_done_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.run_length == 8'd0) && !out_data.clipped
    |-> out_data.image_done && (out_data.pixel_index == 24'd0)
        && (out_data.pixel_value == 8'd0))
    else $error("malformed done marker");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind rle8_bitmap_decoder_core rle8bd_checker u_rle8bd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
